@@ rtl/brtp_pkg.sv @@
// ----------------------------------------------------------------------------
// brtp_pkg
// Shared widths and constants of the base relocation table parser.
// ----------------------------------------------------------------------------
package brtp_pkg;

    // Field widths
    localparam int unsigned HW_W       = 16;
    localparam int unsigned DIR_W      = 32;
    localparam int unsigned ADDR_W     = 33;
    localparam int unsigned OFFSET_W   = 12;
    localparam int unsigned ENTRIES_W  = 31;

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Register indexes (byte address is four times the index)
    localparam logic [CFG_ADDR_W-3:0] REG_DIRECTORY_SIZE = 1'b0;

    // Entry halfword fields
    localparam logic [HW_W-1:0] TYPE_MASK   = 16'hf000;
    localparam logic [HW_W-1:0] OFFSET_MASK = 16'h0fff;

endpackage

@@ rtl/brtp_in_if.sv @@
// ----------------------------------------------------------------------------
// brtp_in_if
// Input channel: one halfword of the relocation directory per transfer.
// ----------------------------------------------------------------------------
interface brtp_in_if
    import brtp_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [HW_W-1:0] halfword;
    logic            first;

    modport source (output valid, output halfword, output first, input ready);
    modport sink   (input valid, input halfword, input first, output ready);
endinterface

@@ rtl/brtp_out_if.sv @@
// ----------------------------------------------------------------------------
// brtp_out_if
// Output channel: one relocation address or end-of-table mark per transfer.
// ----------------------------------------------------------------------------
interface brtp_out_if
    import brtp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] relocation_address;
    logic              has_address;
    logic              end_of_table;

    modport source (output valid, output relocation_address, output has_address,
                    output end_of_table, input ready);
    modport sink   (input valid, input relocation_address, input has_address,
                    input end_of_table, output ready);
endinterface

@@ rtl/brtp_cfg.sv @@
// ----------------------------------------------------------------------------
// brtp_cfg
// APB-style register file holding the relocation directory size.
// ----------------------------------------------------------------------------
module brtp_cfg
    import brtp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [DIR_W-1:0]      o_directory_size
);

    logic [DIR_W-1:0] r_directory_size;
    logic             hit;

    // Decode the register index from the word address
    assign hit = (paddr[CFG_ADDR_W-1:2] == REG_DIRECTORY_SIZE);

    // Capture a write transfer in its access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_directory_size <= '0;
        end else if (psel && penable && pwrite && hit) begin
            r_directory_size <= pwdata[DIR_W-1:0];
        end
    end

    // Return the register on reads, zero elsewhere
    assign prdata           = hit ? r_directory_size : '0;
    assign pready           = 1'b1;
    assign o_directory_size = r_directory_size;

endmodule

@@ rtl/base_relocation_table_parser.sv @@
// ----------------------------------------------------------------------------
// base_relocation_table_parser
// Walks a PE-style base relocation directory delivered as 16-bit halfwords.
// Each block has a page base and a byte size (both low halfword first)
// followed by type/offset entries; a nonzero type yields page base plus
// offset, a zero type silences the rest of its block. Parsing ends on a zero
// or short block size, or once the bytes consumed reach directory_size, and
// that step carries end_of_table. A halfword with first set restarts the walk
// from any point. The block takes one halfword every cycle unless a held
// result stalls it; results are registered. The slowest path is the 33-bit
// byte-count add and compare that closes a block. Halfwords that produce
// nothing leave the output untouched, and no clearing pass follows reset.
// ----------------------------------------------------------------------------
module base_relocation_table_parser
    import brtp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    brtp_in_if.sink               i_in,
    brtp_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [2:0] {
        PH_DONE    = 3'd0,
        PH_BASE_LO = 3'd1,
        PH_BASE_HI = 3'd2,
        PH_SIZE_LO = 3'd3,
        PH_SIZE_HI = 3'd4,
        PH_ENTRY   = 3'd5
    } t_phase;

    logic [DIR_W-1:0]     directory_size;

    t_phase               r_phase,          n_phase;
    logic [DIR_W-1:0]     r_page_base,      n_page_base;
    logic [DIR_W-1:0]     r_block_length,   n_block_length;
    logic [ENTRIES_W-1:0] r_entries_left,   n_entries_left;
    logic [ADDR_W-1:0]    r_bytes_consumed, n_bytes_consumed;
    logic                 r_skipping_rest,  n_skipping_rest;

    logic                 r_out_valid;
    logic [ADDR_W-1:0]    r_out_address;
    logic                 r_out_has;
    logic                 r_out_end;

    logic                 res_valid;
    logic [ADDR_W-1:0]    res_address;
    logic                 res_has;
    logic                 res_end;

    logic                 accept;
    t_phase               cur_phase;
    logic [DIR_W-1:0]     size_word;
    logic [DIR_W-1:0]     close_len;
    logic [ADDR_W-1:0]    bytes_sum;
    logic                 close_end;
    logic [ENTRIES_W-1:0] entries_dec;
    logic [ENTRIES_W-1:0] size_entries;

    // Configuration registers
    brtp_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_directory_size (directory_size)
    );

    // Take a halfword whenever the result register is free or being drained
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // Shared block-close arithmetic
    assign cur_phase    = i_in.first ? PH_BASE_LO : r_phase;
    assign size_word    = {i_in.halfword, r_block_length[HW_W-1:1], 1'b0};
    assign size_entries = size_word[DIR_W-1:1] - ENTRIES_W'(4);
    assign close_len    = (cur_phase == PH_SIZE_HI) ? size_word : r_block_length;
    assign bytes_sum    = r_bytes_consumed + {1'b0, close_len};
    assign close_end    = (bytes_sum >= {1'b0, directory_size});
    assign entries_dec  = r_entries_left - ENTRIES_W'(1);

    // Decode one halfword against the current phase
    always_comb begin
        n_phase          = r_phase;
        n_page_base      = r_page_base;
        n_block_length   = r_block_length;
        n_entries_left   = r_entries_left;
        n_bytes_consumed = r_bytes_consumed;
        n_skipping_rest  = r_skipping_rest;
        res_valid        = 1'b0;
        res_address      = '0;
        res_has          = 1'b0;
        res_end          = 1'b0;

        if (i_in.first) begin
            n_bytes_consumed = '0;
            n_skipping_rest  = 1'b0;
            n_entries_left   = '0;
        end

        if (i_in.first && (directory_size == '0)) begin
            // Empty directory: finish at once
            n_phase   = PH_DONE;
            res_valid = 1'b1;
            res_end   = 1'b1;
        end else begin
            case (cur_phase)
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                PH_BASE_LO: begin
                    n_page_base = {r_page_base[DIR_W-1:HW_W], i_in.halfword};
                    n_phase     = PH_BASE_HI;
                end
                PH_BASE_HI: begin
                    n_page_base = {i_in.halfword, r_page_base[HW_W-1:0]};
                    n_phase     = PH_SIZE_LO;
                end
                PH_SIZE_LO: begin
                    n_block_length = {r_block_length[DIR_W-1:HW_W], i_in.halfword};
                    n_phase        = PH_SIZE_HI;
                end
                PH_SIZE_HI: begin
                    n_block_length  = size_word;
                    n_skipping_rest = 1'b0;
                    if (size_word[DIR_W-1:3] == '0) begin
                        // Zero or malformed short size ends the table
                        n_phase   = PH_DONE;
                        res_valid = 1'b1;
                        res_end   = 1'b1;
                    end else begin
                        n_entries_left = size_entries;
                        if (size_entries == '0) begin
                            // Header-only block closes straight away
                            n_bytes_consumed = bytes_sum;
                            n_phase          = close_end ? PH_DONE : PH_BASE_LO;
                            res_valid        = close_end;
                            res_end          = close_end;
                        end else begin
                            n_phase = PH_ENTRY;
                        end
                    end
                end
                PH_ENTRY: begin
                    if ((i_in.halfword & TYPE_MASK) == '0) begin
                        n_skipping_rest = 1'b1;
                    end else if (!r_skipping_rest) begin
                        res_has     = 1'b1;
                        res_address = {1'b0, r_page_base}
                                      + ADDR_W'(i_in.halfword & OFFSET_MASK);
                    end
                    n_entries_left = entries_dec;
                    if (entries_dec == '0) begin
                        n_bytes_consumed = bytes_sum;
                        n_phase          = close_end ? PH_DONE : PH_BASE_LO;
                        res_end          = close_end;
                    end
                    res_valid = res_has || res_end;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    // Hold parser state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_DONE;
            r_page_base      <= '0;
            r_block_length   <= '0;
            r_entries_left   <= '0;
            r_bytes_consumed <= '0;
            r_skipping_rest  <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (accept) begin
                r_phase          <= n_phase;
                r_page_base      <= n_page_base;
                r_block_length   <= n_block_length;
                r_entries_left   <= n_entries_left;
                r_bytes_consumed <= n_bytes_consumed;
                r_skipping_rest  <= n_skipping_rest;
            end
            if (accept && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load result payload on a producing transfer
    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out_address <= res_address;
            r_out_has     <= res_has;
            r_out_end     <= res_end;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.relocation_address = r_out_address;
    assign o_out.has_address        = r_out_has;
    assign o_out.end_of_table       = r_out_end;

endmodule
